@@ rtl/core/timestamp_nearest_pairing_core_defines.svh @@
// assertion macros shared by the pairing core
`ifndef TIMESTAMP_NEAREST_PAIRING_CORE_DEFINES_SVH
`define TIMESTAMP_NEAREST_PAIRING_CORE_DEFINES_SVH

// same-cycle implication on clk, off during reset
`define TNP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off during reset
`define TNP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/tnp_pkg.sv @@
`timescale 1ns / 1ps

package tnp_pkg;

	// queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);

	// pairs per service request, capped at fifteen records
	localparam int MAX_PAIRS_PER_SERVICE = 32;
	localparam int PAIR_LIMIT = (MAX_PAIRS_PER_SERVICE < 15) ? MAX_PAIRS_PER_SERVICE : 15;
	localparam int PAIR_W     = $clog2(PAIR_LIMIT + 1);

	// stored payload width and fixed field widths
	localparam int PAYLOAD_WIDTH = 32;
	localparam int PAYLOAD_F_W   = 32;
	localparam int STORE_W = (PAYLOAD_WIDTH < PAYLOAD_F_W) ? PAYLOAD_WIDTH : PAYLOAD_F_W;
	localparam int ACTION_W  = 2;
	localparam int TIME_S_W  = 32;
	localparam int TIME_MS_W = 10;
	localparam int TIME_W    = 42;
	localparam int DIFF_W    = TIME_W + 1;
	localparam int OFFSET_W  = 11;
	localparam int MAX_OFF_W = 10;
	localparam int REC_IDX_W = 32;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = MAX_OFF_W;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_OFFSET = 1'b1;
	localparam logic [MAX_OFF_W-1:0] MAX_OFFSET_RST = 10'd25;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [TIME_W-1:0] time_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WIND    = 2'd0,
		ACT_MOTION  = 2'd1,
		ACT_SERVICE = 2'd2
	} action_t;

	// circular slot advance, any depth
	function automatic ptr_t next_slot(input ptr_t i);
		return (i == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

@@ rtl/core/tnp_req_if.sv @@
`timescale 1ns / 1ps

interface tnp_req_if;
	import tnp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ACTION_W-1:0]  action;
	logic [TIME_S_W-1:0]  time_s;
	logic [TIME_MS_W-1:0] time_ms;
	logic [PAYLOAD_F_W-1:0] payload;

	modport source (output valid, action, time_s, time_ms, payload, input ready);
	modport sink (input valid, action, time_s, time_ms, payload, output ready);
endinterface

@@ rtl/core/tnp_rec_if.sv @@
`timescale 1ns / 1ps

interface tnp_rec_if;
	import tnp_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [REC_IDX_W-1:0]   seq_no;
	logic [PAYLOAD_F_W-1:0] wind_payload;
	logic [PAYLOAD_F_W-1:0] motion_payload;
	logic signed [OFFSET_W-1:0] pair_offset;
	logic                   last;

	modport source (output valid, seq_no, wind_payload, motion_payload, pair_offset,
		last, input ready);
	modport sink (input valid, seq_no, wind_payload, motion_payload, pair_offset,
		last, output ready);
endinterface

@@ rtl/core/timestamp_nearest_pairing_core.sv @@
// channel  dir  carries
// req      in   action, time_s, time_ms, payload (one request)
// rec      out  seq_no, wind_payload, motion_payload, pair_offset, last
// cfg      in   cfg_we / cfg_idx / cfg_wdata register writes
//
// a packet arrival: accept in S_IDLE, then time build and slot write in S_PUSH
// a service request, per pair, has its k motion entries walked
// by the single shared subtract/compare unit, one entry per cycle;
// at most 15 pairs per request; req.ready is high only while idle
// records go through a pending stage and an output register; rec stalls only
// hold the sequencer when both are full. asynchronous reset empties both queues
`timescale 1ns / 1ps
`include "timestamp_nearest_pairing_core_defines.svh"

module timestamp_nearest_pairing_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tnp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tnp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	tnp_req_if.sink                         req,
	tnp_rec_if.source                       rec
);
	import tnp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_PREP,
		S_SCAN,
		S_DECIDE,
		S_LOAD,
		S_FLUSH
	} state_t;

	state_t state_q;

	// configuration
	logic                 enable_q;
	logic [MAX_OFF_W-1:0] max_off_q;

	// queue pointers and status
	ptr_t                 wind_head_q, wind_tail_q, mot_head_q, mot_tail_q;
	logic                 desync_q;
	logic [REC_IDX_W-1:0] rec_cnt_q;
	logic [PAIR_W-1:0]    n_q;

	// latched arrival
	logic                 is_motion_q;
	logic [TIME_S_W-1:0]  ts_q;
	logic [TIME_MS_W-1:0] tms_q;
	logic [STORE_W-1:0]   pl_q;

	// slot stores
	time_t              wind_time_mem [QUEUE_DEPTH];
	logic [STORE_W-1:0] wind_pl_mem   [QUEUE_DEPTH];
	time_t              mot_time_mem  [QUEUE_DEPTH];
	logic [STORE_W-1:0] mot_pl_mem    [QUEUE_DEPTH];

	// registered read data
	time_t              wt_rd_q, mt_rd_q;
	logic [STORE_W-1:0] wp_rd_q, mp_rd_q;

	// search state
	ptr_t                       cur_q, best_q;
	logic [MAX_OFF_W-1:0]       best_abs_q;
	logic signed [OFFSET_W-1:0] best_diff_q;
	logic                       found_q;

	// pending record, last flag known one pair later
	logic                       pend_v_q;
	logic [REC_IDX_W-1:0]       pend_idx_q;
	logic [PAYLOAD_F_W-1:0]     pend_wp_q, pend_mp_q;
	logic signed [OFFSET_W-1:0] pend_off_q;

	// output register
	logic                       out_v_q, out_last_q;
	logic [REC_IDX_W-1:0]       out_idx_q;
	logic [PAYLOAD_F_W-1:0]     out_wp_q, out_mp_q;
	logic signed [OFFSET_W-1:0] out_off_q;

	logic                       req_take, out_free, out_load, load_go;
	time_t                      push_time;
	ptr_t                       push_head, push_tail, mot_rd_addr;
	logic                       push_full, wind_we, mot_we;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [OFFSET_W-1:0] diff_lo;
	logic [OFFSET_W-1:0]        abs_lo, max_ext;
	logic                       fits, in_tol, better, late;

	// handshakes
	assign req.ready = (state_q == S_IDLE);
	assign req_take  = req.valid && req.ready;
	assign out_free  = !out_v_q || rec.ready;

	// pending record moves into the output register this cycle
	assign out_load = pend_v_q && out_free && ((state_q == S_LOAD) || (state_q == S_FLUSH));
	assign load_go  = (state_q == S_LOAD) && (!pend_v_q || out_free);

	assign rec.valid          = out_v_q;
	assign rec.seq_no         = out_idx_q;
	assign rec.wind_payload   = out_wp_q;
	assign rec.motion_payload = out_mp_q;
	assign rec.pair_offset    = out_off_q;
	assign rec.last           = out_last_q;

	// time in ms: s * 1000 as s * 1024 - s * 16 - s * 8
	assign push_time = (TIME_W'(ts_q) << 10) - (TIME_W'(ts_q) << 4)
		- (TIME_W'(ts_q) << 3) + TIME_W'(tms_q);

	// full check on the queue being pushed
	assign push_head = is_motion_q ? mot_head_q : wind_head_q;
	assign push_tail = is_motion_q ? mot_tail_q : wind_tail_q;
	assign push_full = (next_slot(push_head) == push_tail);
	assign wind_we   = (state_q == S_PUSH) && !is_motion_q && !push_full;
	assign mot_we    = (state_q == S_PUSH) && is_motion_q && !push_full;

	// motion read walks ahead of the compare by one slot
	assign mot_rd_addr = (state_q == S_SCAN) ? next_slot(cur_q) : mot_tail_q;

	// shared subtract and compare unit
	assign diff    = $signed({1'b0, wt_rd_q} - {1'b0, mt_rd_q});
	assign diff_lo = diff[OFFSET_W-1:0];
	assign fits    = (diff[DIFF_W-1:OFFSET_W-1] == '0) || (diff[DIFF_W-1:OFFSET_W-1] == '1);
	assign abs_lo  = diff_lo[OFFSET_W-1] ? (~diff_lo + 1'b1) : diff_lo;
	assign max_ext = {1'b0, max_off_q};
	assign in_tol  = fits && (abs_lo <= max_ext);
	assign better  = in_tol && (!found_q || (abs_lo < {1'b0, best_abs_q}));
	assign late    = diff[DIFF_W-1] && (!fits || (abs_lo > max_ext));

	// wind stores
	always_ff @(posedge clk) begin
		if (wind_we) begin
			wind_time_mem[wind_head_q] <= push_time;
			wind_pl_mem[wind_head_q]   <= pl_q;
		end
		wt_rd_q <= wind_time_mem[wind_tail_q];
		wp_rd_q <= wind_pl_mem[wind_tail_q];
	end

	// motion stores
	always_ff @(posedge clk) begin
		if (mot_we) begin
			mot_time_mem[mot_head_q] <= push_time;
			mot_pl_mem[mot_head_q]   <= pl_q;
		end
		mt_rd_q <= mot_time_mem[mot_rd_addr];
		mp_rd_q <= mot_pl_mem[best_q];
	end

	// sequencer, queue control and record registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			enable_q    <= 1'b0;
			max_off_q   <= MAX_OFFSET_RST;
			wind_head_q <= '0;
			wind_tail_q <= '0;
			mot_head_q  <= '0;
			mot_tail_q  <= '0;
			desync_q    <= 1'b0;
			rec_cnt_q   <= '0;
			n_q         <= '0;
			is_motion_q <= 1'b0;
			ts_q        <= '0;
			tms_q       <= '0;
			pl_q        <= '0;
			cur_q       <= '0;
			best_q      <= '0;
			best_abs_q  <= '0;
			best_diff_q <= '0;
			found_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_idx_q  <= '0;
			pend_wp_q   <= '0;
			pend_mp_q   <= '0;
			pend_off_q  <= '0;
			out_v_q     <= 1'b0;
			out_last_q  <= 1'b0;
			out_idx_q   <= '0;
			out_wp_q    <= '0;
			out_mp_q    <= '0;
			out_off_q   <= '0;
		end else begin
			// register writes
			if (cfg_we) begin
				if (cfg_idx == REG_ENABLE) begin
					enable_q <= cfg_wdata[0];
				end else if (cfg_idx == REG_MAX_OFFSET) begin
					max_off_q <= cfg_wdata[MAX_OFF_W-1:0];
				end
			end

			// output register drains unless refilled this cycle
			if (rec.ready && !out_load) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						ts_q        <= req.time_s;
						tms_q       <= req.time_ms;
						pl_q        <= req.payload[STORE_W-1:0];
						is_motion_q <= (req.action == ACT_MOTION);
						if ((req.action == ACT_WIND) || (req.action == ACT_MOTION)) begin
							state_q <= S_PUSH;
						end else if ((req.action == ACT_SERVICE) && enable_q) begin
							n_q     <= '0;
							state_q <= S_PREP;
						end
					end
				end
				S_PUSH: begin
					// overflow drops the packet and empties both queues
					if (push_full) begin
						desync_q    <= 1'b1;
						wind_head_q <= '0;
						wind_tail_q <= '0;
						mot_head_q  <= '0;
						mot_tail_q  <= '0;
					end else if (is_motion_q) begin
						mot_head_q <= next_slot(mot_head_q);
					end else begin
						wind_head_q <= next_slot(wind_head_q);
					end
					state_q <= S_IDLE;
				end
				S_PREP: begin
					if ((wind_tail_q == wind_head_q) || (n_q == PAIR_W'(PAIR_LIMIT))) begin
						state_q <= S_FLUSH;
					end else begin
						cur_q   <= mot_tail_q;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// one motion entry per cycle, stop past tolerance
					if (cur_q == mot_head_q) begin
						state_q <= S_DECIDE;
					end else begin
						if (better) begin
							best_q      <= cur_q;
							best_abs_q  <= abs_lo[MAX_OFF_W-1:0];
							best_diff_q <= diff_lo;
							found_q     <= 1'b1;
						end
						if (late) begin
							state_q <= S_DECIDE;
						end else begin
							cur_q <= next_slot(cur_q);
						end
					end
				end
				S_DECIDE: begin
					if (found_q) begin
						state_q <= S_LOAD;
					end else begin
						if (desync_q) begin
							wind_head_q <= '0;
							wind_tail_q <= '0;
							mot_head_q  <= '0;
							mot_tail_q  <= '0;
						end
						state_q <= S_FLUSH;
					end
				end
				S_LOAD: begin
					// older pending record moves out, new pair becomes pending
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_v_q    <= 1'b1;
							out_last_q <= 1'b0;
							out_idx_q  <= pend_idx_q;
							out_wp_q   <= pend_wp_q;
							out_mp_q   <= pend_mp_q;
							out_off_q  <= pend_off_q;
						end
						pend_v_q    <= 1'b1;
						pend_idx_q  <= rec_cnt_q;
						pend_wp_q   <= PAYLOAD_F_W'(wp_rd_q);
						pend_mp_q   <= PAYLOAD_F_W'(mp_rd_q);
						pend_off_q  <= best_diff_q;
						rec_cnt_q   <= rec_cnt_q + 1'b1;
						wind_tail_q <= next_slot(wind_tail_q);
						mot_tail_q  <= next_slot(best_q);
						desync_q    <= 1'b0;
						n_q         <= n_q + 1'b1;
						state_q     <= S_PREP;
					end
				end
				S_FLUSH: begin
					// final record of the request carries last
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_v_q    <= 1'b1;
						out_last_q <= 1'b1;
						out_idx_q  <= pend_idx_q;
						out_wp_q   <= pend_wp_q;
						out_mp_q   <= pend_mp_q;
						out_off_q  <= pend_off_q;
						pend_v_q   <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`TNP_ASSERT_IMP(a_pend_not_idle, pend_v_q, state_q != S_IDLE, "pending record in idle")
	`TNP_ASSERT_IMP(a_not_last_has_next, out_v_q && !out_last_q, pend_v_q, "no successor")
	`TNP_ASSERT_IMP(a_best_in_tol, state_q == S_LOAD, best_abs_q <= max_off_q, "out of tolerance")
	`TNP_ASSERT_IMP(a_pair_limit, state_q == S_SCAN, n_q < PAIR_W'(PAIR_LIMIT), "too many pairs")
	`TNP_ASSERT_NEXT(a_load_pops, load_go, wind_tail_q != $past(wind_tail_q), "wind not popped")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import tnp_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int WIND_Q        = 0;
	localparam int MOTION_Q      = 1;
	localparam int SETTLE_CYCLES = 400;
	localparam int HOLD_CYCLES   = 1500;
	localparam int QUIET_LIMIT   = 10000;

	typedef enum logic [1:0] {RDY_FREE, RDY_COIN, RDY_PATTERN} rdy_mode_t;

	typedef struct {
		logic [ACTION_W-1:0]    action;
		logic [TIME_S_W-1:0]    time_s;
		logic [TIME_MS_W-1:0]   time_ms;
		logic [PAYLOAD_F_W-1:0] payload;
	} packet_t;

	typedef struct {
		logic [REC_IDX_W-1:0]       seq_no;
		logic [PAYLOAD_F_W-1:0]     wind_payload;
		logic [PAYLOAD_F_W-1:0]     motion_payload;
		logic signed [OFFSET_W-1:0] pair_offset;
		logic                       last;
	} record_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tnp_req_if req ();
	tnp_rec_if rec ();

	timestamp_nearest_pairing_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.rec      (rec)
	);

	// mirror of the two packet queues and the pairing state
	time_t                slot_when [2][QUEUE_DEPTH];
	logic [STORE_W-1:0]   slot_tag [2][QUEUE_DEPTH];
	int                   wr_at [2];
	int                   rd_at [2];
	bit                   out_of_sync;
	logic [REC_IDX_W-1:0] records_made;
	bit                   en_reg;
	logic [MAX_OFF_W-1:0] tol_reg;

	record_t owed_records [$];
	packet_t packet_backlog [$];
	packet_t on_bus;

	int     errors, queued_items;
	int     n_wind, n_motion, n_service, n_ignored, n_records;
	int     burst_left = 1;
	int     gap_left;
	bit     hold_kick;
	longint stamp_cursor;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int step_slot(int i);
		return (i + 1) % QUEUE_DEPTH;
	endfunction

	function automatic void flush_queues();
		wr_at[WIND_Q] = 0;
		rd_at[WIND_Q] = 0;
		wr_at[MOTION_Q] = 0;
		rd_at[MOTION_Q] = 0;
	endfunction

	// a packet on a full queue is dropped and wipes both queues
	function automatic void store_packet(int q, time_t t, logic [STORE_W-1:0] tag);
		if (step_slot(wr_at[q]) == rd_at[q]) begin
			out_of_sync = 1'b1;
			flush_queues();
		end else begin
			slot_when[q][wr_at[q]] = t;
			slot_tag[q][wr_at[q]] = tag;
			wr_at[q] = step_slot(wr_at[q]);
		end
	endfunction

	// update the mirror with one accepted request, queue the records it owes
	function automatic void advance_pairing(packet_t p);
		time_t   t;
		int      made, m, best;
		bit      found, have_prev;
		longint  wt, d, a, best_abs, best_d, tol;
		record_t r, prev;
		t = time_t'(p.time_s) * time_t'(1000) + time_t'(p.time_ms);
		tol = longint'(tol_reg);
		made = 0;
		have_prev = 1'b0;
		case (p.action)
		ACT_WIND: store_packet(WIND_Q, t, p.payload[STORE_W-1:0]);
		ACT_MOTION: store_packet(MOTION_Q, t, p.payload[STORE_W-1:0]);
		ACT_SERVICE: if (en_reg) begin
			while (rd_at[WIND_Q] != wr_at[WIND_Q] && made < PAIR_LIMIT) begin
				wt = longint'(slot_when[WIND_Q][rd_at[WIND_Q]]);
				m = rd_at[MOTION_Q];
				found = 1'b0;
				best = 0;
				best_abs = 0;
				best_d = 0;
				// nearest motion entry, earliest on a tie, stop once past the window
				while (m != wr_at[MOTION_Q]) begin
					d = wt - longint'(slot_when[MOTION_Q][m]);
					a = (d < 0) ? -d : d;
					if (!found || a < best_abs) begin
						found = 1'b1;
						best = m;
						best_abs = a;
						best_d = d;
					end
					if (d < -tol)
						break;
					m = step_slot(m);
				end
				if (!found || best_abs > tol) begin
					if (out_of_sync)
						flush_queues();
					break;
				end
				if (have_prev)
					owed_records.push_back(prev);
				r.seq_no = records_made;
				r.wind_payload = PAYLOAD_F_W'(slot_tag[WIND_Q][rd_at[WIND_Q]]);
				r.motion_payload = PAYLOAD_F_W'(slot_tag[MOTION_Q][best]);
				r.pair_offset = best_d[OFFSET_W-1:0];
				r.last = 1'b0;
				prev = r;
				have_prev = 1'b1;
				made++;
				records_made++;
				rd_at[WIND_Q] = step_slot(rd_at[WIND_Q]);
				rd_at[MOTION_Q] = step_slot(best);
				out_of_sync = 1'b0;
			end
			if (have_prev) begin
				prev.last = 1'b1;
				owed_records.push_back(prev);
			end
		end
		default: ;
		endcase
	endfunction

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, what, want, got);
		end
	endfunction

	// request driver: bursts of requests with random gaps
	always @(posedge clk) begin : driver
		bit fire;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				advance_pairing(on_bus);
				case (on_bus.action)
				ACT_WIND: n_wind++;
				ACT_MOTION: n_motion++;
				ACT_SERVICE: n_service++;
				default: n_ignored++;
				endcase
			end
			if (!req.valid || req.ready) begin
				fire = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (packet_backlog.size() != 0) begin
					on_bus = packet_backlog.pop_front();
					fire = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end
				req.valid <= fire;
				if (fire) begin
					req.action <= on_bus.action;
					req.time_s <= on_bus.time_s;
					req.time_ms <= on_bus.time_ms;
					req.payload <= on_bus.payload;
				end
			end
		end
	end

	// record monitor and receiver stall pattern
	always @(posedge clk) begin : monitor
		record_t   want;
		logic      nxt_ready;
		bit        hold_seen;
		int        hold_left, mode_left;
		rdy_mode_t mode;
		logic [31:0] stall_pat;
		if (arst_n) begin
			if (rec.valid && rec.ready) begin
				n_records++;
				if (owed_records.size() == 0) begin
					errors++;
					$display("%0t: record %0h arrived with none expected", $time,
						rec.seq_no);
				end else begin
					want = owed_records.pop_front();
					check_field("seq_no", want.seq_no, rec.seq_no);
					check_field("wind_payload", want.wind_payload, rec.wind_payload);
					check_field("motion_payload", want.motion_payload, rec.motion_payload);
					check_field("pair_offset", 32'(want.pair_offset), 32'(rec.pair_offset));
					check_field("last", 32'(want.last), 32'(rec.last));
				end
			end
			// long hold-off on request, else a stall mode that changes now and then
			if (hold_kick != hold_seen) begin
				hold_seen = hold_kick;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt_ready = 1'b0;
			end else begin
				if (mode_left <= 0) begin
					mode = rdy_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(16, 96);
					stall_pat = $urandom;
				end
				mode_left--;
				case (mode)
				RDY_COIN: nxt_ready = 1'($urandom_range(0, 1));
				RDY_PATTERN: begin
					nxt_ready = stall_pat[0];
					stall_pat = {stall_pat[0], stall_pat[31:1]};
				end
				default: nxt_ready = 1'b1;
				endcase
			end
			rec.ready <= nxt_ready;
		end
	end

	// watchdog on cycles without any handshake
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req.valid && req.ready) || (rec.valid && rec.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: nothing accepted for %0d cycles", $time, QUIET_LIMIT);
		$display("** timestamp_nearest_pairing_core: FAILED **");
		$finish;
	end

	function automatic void push_raw(logic [ACTION_W-1:0] act, logic [TIME_S_W-1:0] s,
		logic [TIME_MS_W-1:0] ms, logic [PAYLOAD_F_W-1:0] pay);
		packet_t p;
		p.action = act;
		p.time_s = s;
		p.time_ms = ms;
		p.payload = pay;
		packet_backlog.push_back(p);
		if (act != ACT_UNUSED && !(act == ACT_SERVICE && !en_reg))
			queued_items++;
	endfunction

	// packet at a millisecond stamp, sometimes with the ms part above 999
	function automatic void push_at(logic [ACTION_W-1:0] act, longint t);
		logic [TIME_S_W-1:0]  s;
		logic [TIME_MS_W-1:0] ms;
		s = TIME_S_W'(t / 1000);
		ms = TIME_MS_W'(t % 1000);
		if (s != 0 && ms < 24 && $urandom_range(0, 3) == 0) begin
			s = s - 1;
			ms = ms + TIME_MS_W'(1000);
		end
		push_raw(act, s, ms, $urandom);
	endfunction

	function automatic void push_service();
		push_raw(ACT_SERVICE, $urandom, TIME_MS_W'($urandom_range(0, 1023)), $urandom);
	endfunction

	// overflow the wind queue, then serve: leaves both queues empty when enabled
	function automatic void resync();
		for (int i = 0; i < QUEUE_DEPTH; i++)
			push_raw(ACT_WIND, $urandom, TIME_MS_W'($urandom_range(0, 1023)), $urandom);
		push_service();
	endfunction

	// well-formed run: each wind within tolerance of its own motion packet
	function automatic void make_pairs(int npairs);
		longint tol, gap, base, jit;
		int     split, i;
		tol = longint'(tol_reg);
		gap = 2 * tol + 64;
		split = ($urandom_range(0, 3) == 0) ? $urandom_range(1, npairs) : npairs + 1;
		for (i = 0; i < npairs; i++) begin
			base = stamp_cursor + longint'(i) * gap;
			case ($urandom_range(0, 3))
			0: jit = tol;
			1: jit = -tol;
			default: jit = longint'($urandom_range(0, 2 * tol_reg)) - tol;
			endcase
			if ($urandom_range(0, 1)) begin
				push_at(ACT_MOTION, base);
				push_at(ACT_WIND, base + jit);
			end else begin
				push_at(ACT_WIND, base + jit);
				push_at(ACT_MOTION, base);
			end
			// spare later motion packet, may win or be skipped
			if ($urandom_range(0, 3) == 0)
				push_at(ACT_MOTION, base + longint'($urandom_range(1, 40)));
			if (i + 1 == split)
				push_service();
		end
		push_service();
		stamp_cursor += longint'(npairs) * gap + longint'($urandom_range(0, 3000));
	endfunction

	function automatic void fill_random(int quota);
		int first, pick, n, i;
		first = queued_items;
		while (queued_items - first < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				make_pairs(($urandom_range(0, 7) == 0) ? PAIR_LIMIT : $urandom_range(1, 6));
			end else if (pick < 74) begin
				// arbitrary fields, any action
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					push_raw(ACTION_W'($urandom_range(0, 3)), $urandom,
						TIME_MS_W'($urandom_range(0, 1023)), $urandom);
				resync();
			end else if (pick < 84) begin
				// wind with its only motion packet outside the window
				push_at(ACT_WIND, stamp_cursor);
				push_at(ACT_MOTION,
					stamp_cursor + longint'(tol_reg) + longint'($urandom_range(1, 50)));
				push_service();
				stamp_cursor += 3000;
				resync();
			end else if (pick < 90) begin
				// motion queue overflow
				for (i = 0; i < QUEUE_DEPTH; i++) begin
					push_at(ACT_MOTION, stamp_cursor);
					stamp_cursor += longint'($urandom_range(1, 100));
				end
				resync();
			end else begin
				// motion packets and a service with no wind waiting
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++) begin
					push_at(ACT_MOTION, stamp_cursor);
					stamp_cursor += longint'($urandom_range(1, 100));
				end
				push_service();
			end
		end
	endfunction

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ENABLE)
			en_reg = val[0];
		else
			tol_reg = MAX_OFF_W'(val);
	endtask

	// all requests in, all records out, then room for a silent service to finish
	task automatic settle();
		@(negedge clk);
		while (packet_backlog.size() != 0 || req.valid || owed_records.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(bit en, int tol, int quota, bit squeeze);
		set_reg(REG_ENABLE, int'(en));
		set_reg(REG_MAX_OFFSET, tol);
		stamp_cursor = longint'($urandom_range(2, 32'hFFF0_0000)) * 1000;
		@(negedge clk);
		if (squeeze)
			hold_kick <= ~hold_kick;
		resync();
		if (squeeze)
			make_pairs(6);
		fill_random(quota);
		settle();
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_ENABLE;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.action = ACT_UNUSED;
		req.time_s = '0;
		req.time_ms = '0;
		req.payload = '0;
		rec.ready = 1'b0;
		hold_kick = 1'b0;
		flush_queues();
		out_of_sync = 1'b0;
		records_made = '0;
		en_reg = 1'b0;
		tol_reg = MAX_OFFSET_RST;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: tolerance edges, tie, ms above 999, largest time, no match
		set_reg(REG_ENABLE, 1);
		set_reg(REG_MAX_OFFSET, 25);
		@(negedge clk);
		push_raw(ACT_SERVICE, '0, '0, '0);
		push_raw(ACT_UNUSED, '1, '1, '1);
		push_raw(ACT_MOTION, 32'd0, 10'd10, 32'hFFFF_FFFF);
		push_raw(ACT_MOTION, 32'd1, 10'd0, 32'h0000_0001);
		push_raw(ACT_MOTION, 32'd1, 10'd995, 32'h8000_0000);
		push_raw(ACT_MOTION, 32'd2, 10'd5, 32'h5555_5555);
		push_raw(ACT_WIND, 32'd0, 10'd35, 32'h0000_0000);
		push_raw(ACT_WIND, 32'd0, 10'd975, 32'h7FFF_FFFF);
		push_raw(ACT_WIND, 32'd1, 10'd1000, 32'hAAAA_AAAA);
		push_raw(ACT_WIND, 32'd2, 10'd6, 32'h1234_5678);
		push_service();
		push_raw(ACT_MOTION, 32'hFFFF_FFFF, 10'd999, 32'hDEAD_0001);
		push_raw(ACT_WIND, 32'hFFFF_FFFF, 10'd1023, 32'hDEAD_0002);
		push_service();
		push_raw(ACT_WIND, 32'd5, 10'd0, 32'h0F0F_0F0F);
		push_service();
		settle();

		run_phase(1'b1, 25, 25, 1'b1);
		run_phase(1'b0, 1023, 15, 1'b0);
		run_phase(1'b1, 1023, 25, 1'b0);
		run_phase(1'b1, 0, 25, 1'b0);
		run_phase(1'b1, $urandom_range(1, 200), 20, 1'b0);

		if (owed_records.size() != 0) begin
			errors++;
			$display("%0t: %0d expected records never arrived", $time, owed_records.size());
		end
		$display("requests: %0d wind, %0d motion, %0d service, %0d unused; records: %0d",
			n_wind, n_motion, n_service, n_ignored, n_records);
		$display("tolerances 0, 25, 1023 and one random, recording on and off, long stall");
		if (errors == 0)
			$display("** timestamp_nearest_pairing_core: PASSED **");
		else
			$display("** timestamp_nearest_pairing_core: FAILED **");
		$finish;
	end

endmodule
